/* sv/epvt_pkg.sv */
package epvt_pkg;

  // fixed field and register widths
  localparam int IN_CNT_W = 16;
  localparam int MARK_W   = 16;
  localparam int TIME_W   = 24;
  localparam int CPR_W    = 24;
  localparam int DPC_W    = 32;
  localparam int OFF_W    = 48;
  localparam int POS_W    = 48;
  localparam int VEL_W    = 48;
  localparam int DIST_W   = 64;
  localparam int PROD_W   = 80;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 64;

  // register indexes (byte address bits [4:3])
  localparam logic [1:0] REG_CPR = 2'd0;
  localparam logic [1:0] REG_DPC = 2'd1;
  localparam logic [1:0] REG_OFF = 2'd2;

  localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
  localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
  localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_POS,
    ST_MOD,
    ST_MULD_S,
    ST_MULD,
    ST_MULV_S,
    ST_MULV,
    ST_DIV_S,
    ST_DIV,
    ST_OUT
  } epvt_state_t;

  // status of a multi-cycle arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } epvt_unit_sts_t;

endpackage

/* sv/epvt_wmem.sv */
module epvt_wmem #(
  parameter int DEPTH = 10,
  parameter int AW    = 4,
  parameter int DW    = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [DW-1:0]    rd_q_r;
  logic             rd_vld_r;

  // window storage, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // entry valid bits, an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

/* sv/epvt_mul.sv */
module epvt_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [epvt_pkg::POS_W-1:0]    a,
  input  logic [epvt_pkg::DPC_W-1:0]    b,
  output logic [epvt_pkg::PROD_W-1:0]   p,
  output epvt_pkg::epvt_unit_sts_t      sts
);

  localparam int CNT_W = $clog2(epvt_pkg::POS_W);

  logic [epvt_pkg::PROD_W-1:0] acc_r;
  logic [epvt_pkg::POS_W-1:0]  a_r;
  logic [epvt_pkg::DPC_W-1:0]  b_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        busy_r;
  logic                        done_r;

  // step control, one multiplier bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(epvt_pkg::POS_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // shift and add, msb first
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
    end else if (busy_r) begin
      acc_r <= {acc_r[epvt_pkg::PROD_W-2:0], 1'b0}
             + (a_r[epvt_pkg::POS_W-1] ? epvt_pkg::PROD_W'(b_r) : '0);
      a_r   <= {a_r[epvt_pkg::POS_W-2:0], 1'b0};
    end
  end

  assign p        = acc_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

/* sv/epvt_div.sv */
module epvt_div #(
  parameter int DEN_W = 28
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [epvt_pkg::PROD_W-1:0]  n,
  input  logic [DEN_W-1:0]             d,
  output logic [epvt_pkg::PROD_W-1:0]  q,
  output logic [DEN_W-1:0]             rem,
  output epvt_pkg::epvt_unit_sts_t     sts
);

  localparam int CNT_W = $clog2(epvt_pkg::PROD_W);

  logic [epvt_pkg::PROD_W-1:0] q_r;
  logic [DEN_W-1:0]            rem_r;
  logic [DEN_W-1:0]            d_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [DEN_W:0]              trial;
  logic [DEN_W:0]              diff;
  logic                        fits;

  // one restoring step
  always_comb begin
    trial = {rem_r, q_r[epvt_pkg::PROD_W-1]};
    diff  = trial - {1'b0, d_r};
    fits  = trial >= {1'b0, d_r};
  end

  // step control, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(epvt_pkg::PROD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // partial remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= n;
      rem_r <= '0;
      d_r   <= d;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q_r   <= {q_r[epvt_pkg::PROD_W-2:0], fits};
    end
  end

  assign q        = q_r;
  assign rem      = rem_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

/* sv/encoder_position_velocity_tracker.sv */
// one item in flight: the next item is accepted once the result is queued
// the serial multiplier (48 steps, run twice) and radix-2 divider (80 steps, run for
//   rotary wrap and again for velocity) do the arithmetic; a zero window time skips
//   the velocity divide
// reset: synchronous active low, position, window sums and slot cleared at once,
//   window entries invalidated by valid bits, no clearing pass
module encoder_position_velocity_tracker #(
  parameter int WINDOW_LEN   = 10,
  parameter int COUNTER_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // counter_value[15:0], capture_value[31:16], elapsed_time[55:32]
  input  logic [55:0]                   in_tdata,
  // index_captured[0]
  input  logic [0:0]                    in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // distance[63:0], velocity[111:64], zero_mark[127:112]
  output logic [127:0]                  out_tdata,
  // velocity_valid[0]
  output logic [0:0]                    out_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [epvt_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [epvt_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [epvt_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int CB     = COUNTER_BITS;
  localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int XS_W   = CB + SLOT_W;
  localparam int TS_W   = epvt_pkg::TIME_W + SLOT_W;
  localparam int ENT_W  = CB + epvt_pkg::TIME_W;
  localparam int TW     = epvt_pkg::TIME_W;

  epvt_pkg::epvt_state_t state_r, state_nxt;

  // configuration registers
  logic [epvt_pkg::CPR_W-1:0] cpr_r;
  logic [epvt_pkg::DPC_W-1:0] dpc_r;
  logic [epvt_pkg::OFF_W-1:0] off_r;
  logic                       cfg_wr;

  // item being worked on
  logic [CB-1:0]               cur_r;
  logic                        cap_r;
  logic [epvt_pkg::MARK_W-1:0] capv_r;
  logic [TW-1:0]               dt_r;

  // tracker state
  logic [CB-1:0]              last_counter_r;
  logic [epvt_pkg::POS_W-1:0] position_count_r;
  logic [XS_W-1:0]            xs_sum_r;
  logic [TS_W-1:0]            ts_sum_r;
  logic [SLOT_W-1:0]          slot_r;

  // results
  logic [epvt_pkg::PROD_W+1:0] dist_raw_r;
  logic [epvt_pkg::VEL_W-1:0]  vel_r;
  logic                        vvalid_r;
  logic [127:0]                out_tdata_r;
  logic [0:0]                  out_tuser_r;
  logic                        out_tvalid_r;

  logic                        in_acc;
  logic                        upd;
  logic [ENT_W-1:0]            mem_rd;
  logic [CB-1:0]               old_d;
  logic [TW-1:0]               old_t;
  logic [CB-1:0]               ref_cnt;
  logic [CB-1:0]               delta;
  logic [epvt_pkg::POS_W-1:0]  pos_base;
  logic [epvt_pkg::POS_W:0]    pos_sum;
  logic [epvt_pkg::POS_W-1:0]  pos_sat;
  logic [XS_W-1:0]             xs_nxt;
  logic [TS_W-1:0]             ts_nxt;
  logic [SLOT_W-1:0]           slot_nxt;
  logic [epvt_pkg::POS_W-1:0]  pos_mag;
  logic [XS_W-1:0]             xs_mag;
  logic [epvt_pkg::DPC_W-1:0]  dpc_mag;
  logic [TS_W-1:0]             wrap_pos;

  logic                        mul_start;
  logic [epvt_pkg::POS_W-1:0]  mul_a;
  logic [epvt_pkg::PROD_W-1:0] mul_p;
  epvt_pkg::epvt_unit_sts_t    mul_sts;
  logic                        div_start;
  logic [epvt_pkg::PROD_W-1:0] div_n;
  logic [TS_W-1:0]             div_d;
  logic [epvt_pkg::PROD_W-1:0] div_q;
  logic [TS_W-1:0]             div_rem;
  epvt_pkg::epvt_unit_sts_t    div_sts;

  logic [epvt_pkg::PROD_W:0]   prod_s;
  logic [epvt_pkg::PROD_W+1:0] dist_nxt;
  logic [epvt_pkg::DIST_W-1:0] dist_sat;
  logic                        vneg;
  logic                        big_neg;
  logic                        big_pos;
  logic [epvt_pkg::VEL_W-1:0]  vel_nxt;
  logic                        out_load;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r <= '0;
      dpc_r <= epvt_pkg::DPC_W'(65536);
      off_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:3])
        epvt_pkg::REG_CPR: cpr_r <= cfg_pwdata[epvt_pkg::CPR_W-1:0];
        epvt_pkg::REG_DPC: dpc_r <= cfg_pwdata[epvt_pkg::DPC_W-1:0];
        epvt_pkg::REG_OFF: off_r <= cfg_pwdata[epvt_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:3])
      epvt_pkg::REG_CPR: cfg_prdata = epvt_pkg::CFG_DW'(cpr_r);
      epvt_pkg::REG_DPC: cfg_prdata = epvt_pkg::CFG_DW'(dpc_r);
      epvt_pkg::REG_OFF: cfg_prdata = epvt_pkg::CFG_DW'(off_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // input handshake, the window entry at the current slot is read on accept
  assign in_tready = (state_r == epvt_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign upd       = (state_r == epvt_pkg::ST_UPD);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_r  <= CB'(in_tdata[15:0]);
      capv_r <= in_tdata[31:16];
      dt_r   <= in_tdata[55:32];
      cap_r  <= in_tuser[0];
    end
  end

  epvt_wmem #(
    .DEPTH (WINDOW_LEN),
    .AW    (SLOT_W),
    .DW    (ENT_W)
  ) u_wmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (slot_r),
    .rd_data (mem_rd),
    .wr_en   (upd),
    .wr_addr (slot_r),
    .wr_data ({delta, dt_r})
  );

  // delta, saturated position and running window sums
  always_comb begin
    old_d    = mem_rd[ENT_W-1:TW];
    old_t    = mem_rd[TW-1:0];
    ref_cnt  = cap_r ? CB'(capv_r) : last_counter_r;
    delta    = cur_r - ref_cnt;
    pos_base = cap_r ? '0 : position_count_r;
    pos_sum  = {pos_base[epvt_pkg::POS_W-1], pos_base}
             + {{(epvt_pkg::POS_W + 1 - CB){delta[CB-1]}}, delta};
    if (pos_sum[epvt_pkg::POS_W] != pos_sum[epvt_pkg::POS_W-1]) begin
      pos_sat = pos_sum[epvt_pkg::POS_W] ? epvt_pkg::POS_MIN : epvt_pkg::POS_MAX;
    end else begin
      pos_sat = pos_sum[epvt_pkg::POS_W-1:0];
    end
    xs_nxt   = xs_sum_r - {{SLOT_W{old_d[CB-1]}}, old_d} + {{SLOT_W{delta[CB-1]}}, delta};
    ts_nxt   = ts_sum_r - {{SLOT_W{1'b0}}, old_t} + {{SLOT_W{1'b0}}, dt_r};
    slot_nxt = (slot_r == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_r + 1'b1;
  end

  // magnitudes and rotary wrap
  always_comb begin
    pos_mag  = position_count_r[epvt_pkg::POS_W-1] ? -position_count_r : position_count_r;
    xs_mag   = xs_sum_r[XS_W-1] ? -xs_sum_r : xs_sum_r;
    dpc_mag  = dpc_r[epvt_pkg::DPC_W-1] ? -dpc_r : dpc_r;
    wrap_pos = (position_count_r[epvt_pkg::POS_W-1] && (div_rem != '0))
             ? TS_W'(cpr_r) - div_rem : div_rem;
  end

  // shared arithmetic units
  assign mul_start = (state_r == epvt_pkg::ST_MULD_S) || (state_r == epvt_pkg::ST_MULV_S);
  assign mul_a     = (state_r == epvt_pkg::ST_MULD_S) ? pos_mag : epvt_pkg::POS_W'(xs_mag);

  epvt_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (dpc_mag),
    .p     (mul_p),
    .sts   (mul_sts)
  );

  assign div_start = ((state_r == epvt_pkg::ST_POS) && (cpr_r != '0))
                  || (state_r == epvt_pkg::ST_DIV_S);
  assign div_n     = (state_r == epvt_pkg::ST_POS) ? epvt_pkg::PROD_W'(pos_mag) : mul_p;
  assign div_d     = (state_r == epvt_pkg::ST_POS) ? TS_W'(cpr_r) : ts_sum_r;

  epvt_div #(
    .DEN_W (TS_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n     (div_n),
    .d     (div_d),
    .q     (div_q),
    .rem   (div_rem),
    .sts   (div_sts)
  );

  // signed distance before saturation, and velocity clamp
  always_comb begin
    prod_s   = (position_count_r[epvt_pkg::POS_W-1] ^ dpc_r[epvt_pkg::DPC_W-1])
             ? -{1'b0, mul_p} : {1'b0, mul_p};
    dist_nxt = {prod_s[epvt_pkg::PROD_W], prod_s}
             - {{(epvt_pkg::PROD_W + 2 - epvt_pkg::OFF_W){off_r[epvt_pkg::OFF_W-1]}}, off_r};
    if ((&dist_raw_r[epvt_pkg::PROD_W+1:epvt_pkg::DIST_W-1])
        || !(|dist_raw_r[epvt_pkg::PROD_W+1:epvt_pkg::DIST_W-1])) begin
      dist_sat = dist_raw_r[epvt_pkg::DIST_W-1:0];
    end else begin
      dist_sat = dist_raw_r[epvt_pkg::PROD_W+1] ? epvt_pkg::DIST_MIN : epvt_pkg::DIST_MAX;
    end
    vneg    = xs_sum_r[XS_W-1] ^ dpc_r[epvt_pkg::DPC_W-1];
    big_pos = |div_q[epvt_pkg::PROD_W-1:epvt_pkg::VEL_W-1];
    big_neg = (|div_q[epvt_pkg::PROD_W-1:epvt_pkg::VEL_W])
           || (div_q[epvt_pkg::VEL_W-1] && (|div_q[epvt_pkg::VEL_W-2:0]));
    if (vneg) begin
      vel_nxt = big_neg ? epvt_pkg::VEL_MIN : -div_q[epvt_pkg::VEL_W-1:0];
    end else begin
      vel_nxt = big_pos ? epvt_pkg::VEL_MAX : div_q[epvt_pkg::VEL_W-1:0];
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      epvt_pkg::ST_IDLE:   if (in_acc) state_nxt = epvt_pkg::ST_UPD;
      epvt_pkg::ST_UPD:    state_nxt = epvt_pkg::ST_POS;
      epvt_pkg::ST_POS:    state_nxt = (cpr_r != '0) ? epvt_pkg::ST_MOD : epvt_pkg::ST_MULD_S;
      epvt_pkg::ST_MOD:    if (div_sts.done) state_nxt = epvt_pkg::ST_MULD_S;
      epvt_pkg::ST_MULD_S: state_nxt = epvt_pkg::ST_MULD;
      epvt_pkg::ST_MULD:   if (mul_sts.done) state_nxt = epvt_pkg::ST_MULV_S;
      epvt_pkg::ST_MULV_S: state_nxt = epvt_pkg::ST_MULV;
      epvt_pkg::ST_MULV: begin
        if (mul_sts.done) begin
          state_nxt = (ts_sum_r != '0) ? epvt_pkg::ST_DIV_S : epvt_pkg::ST_OUT;
        end
      end
      epvt_pkg::ST_DIV_S:  state_nxt = epvt_pkg::ST_DIV;
      epvt_pkg::ST_DIV:    if (div_sts.done) state_nxt = epvt_pkg::ST_OUT;
      epvt_pkg::ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = epvt_pkg::ST_IDLE;
        end
      end
      default:             state_nxt = epvt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= epvt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // tracker state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_counter_r   <= '0;
      position_count_r <= '0;
      xs_sum_r         <= '0;
      ts_sum_r         <= '0;
      slot_r           <= '0;
    end else if (upd) begin
      last_counter_r   <= cur_r;
      position_count_r <= pos_sat;
      xs_sum_r         <= xs_nxt;
      ts_sum_r         <= ts_nxt;
      slot_r           <= slot_nxt;
    end else if ((state_r == epvt_pkg::ST_MOD) && div_sts.done) begin
      position_count_r <= epvt_pkg::POS_W'(wrap_pos);
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if ((state_r == epvt_pkg::ST_MULD) && mul_sts.done) begin
      dist_raw_r <= dist_nxt;
    end
    if ((state_r == epvt_pkg::ST_MULV) && mul_sts.done) begin
      vel_r    <= '0;
      vvalid_r <= 1'b0;
    end else if ((state_r == epvt_pkg::ST_DIV) && div_sts.done) begin
      vel_r    <= vel_nxt;
      vvalid_r <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {(cap_r ? capv_r : '0), vel_r, dist_sat};
      out_tuser_r <= vvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tvalid = out_tvalid_r;

  // window slot stays inside the window
  assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_W'(WINDOW_LEN - 1))
    else $error("window slot out of range");

  // rotary position lies in one revolution before scaling
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == epvt_pkg::ST_MULD_S) && (cpr_r != '0)
      |-> !position_count_r[epvt_pkg::POS_W-1]
          && (position_count_r < epvt_pkg::POS_W'(cpr_r)))
    else $error("wrapped position outside revolution");

  // invalid velocity is reported as zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tuser_r[0] |-> (out_tdata_r[111:64] == '0))
    else $error("velocity nonzero while not valid");

  // multiplier is never restarted mid run
  assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_sts.busy && !div_sts.busy)
    else $error("multiplier started while busy");

endmodule
